[hdl/range_paint_distinct_count_core_macros.svh]
// assertion helpers for the range paint core
`ifndef RANGE_PAINT_DISTINCT_COUNT_CORE_MACROS_SVH
`define RANGE_PAINT_DISTINCT_COUNT_CORE_MACROS_SVH

// same cycle implication
`define RPDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next cycle implication
`define RPDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rpdc_pkg.sv]
`timescale 1ns / 1ps
package rpdc_pkg;

   localparam int POSITIONS_DEF = 4096;
   localparam int LABELS_DEF    = 1024;
   localparam int CSR_W         = 13;
   localparam int OP_W          = 2;
   localparam int RANGE_W       = 12;
   localparam int LABEL_W       = 10;
   localparam int COUNT_W       = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_PAINT = 2'd1,
      OP_COUNT = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_REDUCE,
      S_CLEAR,
      S_PAINT,
      S_MARK_RD,
      S_MARK_LAB,
      S_MARK_CHK,
      S_UNMARK_RD,
      S_UNMARK_WR,
      S_DONE
   } state_type;

endpackage

[hdl/rpdc_ifs.sv]
`timescale 1ns / 1ps
interface rpdc_req_if import rpdc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [RANGE_W-1:0] range_low;
   logic [RANGE_W-1:0] range_high;
   logic [LABEL_W-1:0] label;

   modport source (output valid, opcode, range_low, range_high, label, input ready);
   modport sink (input valid, opcode, range_low, range_high, label, output ready);
endinterface

interface rpdc_rsp_if import rpdc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] distinct_count;

   modport source (output valid, distinct_count, input ready);
   modport sink (input valid, distinct_count, output ready);
endinterface

[hdl/rpdc_ram.sv]
`timescale 1ns / 1ps
module rpdc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/range_paint_distinct_count_core.sv]
`timescale 1ns / 1ps
// range paint / distinct count core
// req_chan carries one command item (clear, paint range, count range);
// rsp_chan returns exactly one item per command with distinct_count
// (zero except for count). csr_we/csr_wdata set positions_in_use; the user
// must do so only while idle, the core does not enforce it. one command is
// worked at a time; labels per position sit in a one-port-read ram, the
// seen bitmap in a second ram. states per command on the clipped range:
//   clear  S_CLEAR over every position, then S_DONE
//   paint  S_REDUCE, S_PAINT (one position written per cycle), S_DONE
//   count  S_MARK_RD, S_MARK_LAB, S_MARK_CHK per position to mark,
//          then S_UNMARK_RD, S_UNMARK_WR per position to unmark, S_DONE
//   empty count or unused opcode go to S_DONE; empty paint S_REDUCE, S_DONE
// after reset a clearing pass over both rams runs with req ready low.
// the result sits in an output register; a stalled receiver holds the
// finished item there and the next command waits in its final step.
module range_paint_distinct_count_core import rpdc_pkg::*; #(
   parameter int POSITIONS = POSITIONS_DEF,
   parameter int LABELS    = LABELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   rpdc_req_if.sink          req_chan,
   rpdc_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata
);
   `include "range_paint_distinct_count_core_macros.svh"

   localparam int PW   = $clog2(POSITIONS);
   localparam int LW   = $clog2(LABELS);
   localparam int CW   = ((PW + 1) > CSR_W) ? (PW + 1) : CSR_W;
   localparam int MAXD = (POSITIONS > LABELS) ? POSITIONS : LABELS;
   localparam int SW   = $clog2(MAXD);
   localparam int LBW  = ($clog2(LABELS + 1) > LABEL_W) ? $clog2(LABELS + 1) : LABEL_W + 1;

   state_type          state_ff, state_in;
   logic [CW-1:0]      csr_ff;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      sweep_ff, sweep_in;
   logic [PW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [LABEL_W-1:0] lab_ff, lab_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic               empty_ff, empty_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]      used_w, hi_w;
   logic               req_fire;

   logic               pos_we;
   logic [PW-1:0]      pos_waddr, pos_raddr;
   logic [LW-1:0]      pos_wdata, pos_rdata;
   logic               seen_we;
   logic [LW-1:0]      seen_waddr, seen_raddr;
   logic               seen_wdata, seen_rdata;

   rpdc_ram #(.WIDTH(LW), .DEPTH(POSITIONS)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata)
   );

   rpdc_ram #(.WIDTH(1), .DEPTH(LABELS)) u_seen_ram (
      .clock(clock), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
      .raddr(seen_raddr), .rdata(seen_rdata)
   );

   always_comb begin
      if (csr_ff == '0) begin
         used_w = CW'(1);
      end else if (csr_ff > CW'(POSITIONS)) begin
         used_w = CW'(POSITIONS);
      end else begin
         used_w = csr_ff;
      end
      if (CW'(req_chan.range_high) > used_w - CW'(1)) begin
         hi_w = used_w - CW'(1);
      end else begin
         hi_w = CW'(req_chan.range_high);
      end
   end

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.distinct_count = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= CW'(POSITIONS);
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= CW'(csr_wdata);
         end
      end
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      lab_ff   <= lab_in;
      cur_ff   <= cur_in;
      empty_ff <= empty_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lab_in       = lab_ff;
      cur_in       = cur_ff;
      empty_in     = empty_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pos_we       = 1'b0;
      pos_waddr    = idx_ff;
      pos_wdata    = '0;
      pos_raddr    = idx_ff;
      seen_we      = 1'b0;
      seen_waddr   = cur_ff;
      seen_wdata   = 1'b0;
      seen_raddr   = pos_rdata;

      unique case (state_ff)
         S_INIT: begin
            pos_we     = ({1'b0, sweep_ff} < (SW + 1)'(POSITIONS));
            pos_waddr  = PW'(sweep_ff);
            seen_we    = ({1'b0, sweep_ff} < (SW + 1)'(LABELS));
            seen_waddr = LW'(sweep_ff);
            sweep_in   = sweep_ff + SW'(1);
            if (sweep_ff == SW'(MAXD - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               lo_in    = PW'(req_chan.range_low);
               hi_in    = PW'(hi_w);
               empty_in = CW'(req_chan.range_low) > hi_w;
               idx_in   = PW'(req_chan.range_low);
               lab_in   = req_chan.label;
               cnt_in   = '0;
               unique case (opcode_type'(req_chan.opcode))
                  OP_CLEAR: begin
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
                  OP_PAINT: state_in = S_REDUCE;
                  OP_COUNT: state_in = (CW'(req_chan.range_low) > hi_w) ? S_DONE : S_MARK_RD;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_REDUCE: begin
            if (LBW'(lab_ff) >= LBW'(LABELS)) begin
               lab_in = lab_ff - LABEL_W'(LABELS);
            end else begin
               state_in = empty_ff ? S_DONE : S_PAINT;
            end
         end
         S_CLEAR: begin
            pos_we = 1'b1;
            idx_in = idx_ff + PW'(1);
            if (idx_ff == PW'(POSITIONS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_PAINT: begin
            pos_we    = 1'b1;
            pos_wdata = LW'(lab_ff);
            idx_in    = idx_ff + PW'(1);
            if (idx_ff == hi_ff) begin
               state_in = S_DONE;
            end
         end
         S_MARK_RD: state_in = S_MARK_LAB;
         S_MARK_LAB: begin
            cur_in   = pos_rdata;
            state_in = S_MARK_CHK;
         end
         S_MARK_CHK: begin
            if (cur_ff != '0 && !seen_rdata) begin
               seen_we    = 1'b1;
               seen_wdata = 1'b1;
               if (cnt_ff != COUNT_MAX) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end
            if (idx_ff == hi_ff) begin
               idx_in   = lo_ff;
               state_in = S_UNMARK_RD;
            end else begin
               idx_in   = idx_ff + PW'(1);
               state_in = S_MARK_RD;
            end
         end
         S_UNMARK_RD: state_in = S_UNMARK_WR;
         S_UNMARK_WR: begin
            seen_we    = 1'b1;
            seen_waddr = pos_rdata;
            if (idx_ff == hi_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + PW'(1);
               state_in = S_UNMARK_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               res_in       = cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   `RPDC_ASSERT_NEXT(a_item_starts, clock, reset, req_fire, state_ff != S_IDLE, "accepted item did not start")
   `RPDC_ASSERT_NOW(a_mark_nonzero, clock, reset, (state_ff == S_MARK_CHK) && seen_we, cur_ff != '0, "label zero marked as seen")
   `RPDC_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready), rsp_valid_ff && (state_ff == S_IDLE), "finished item not presented")
   `RPDC_ASSERT_NOW(a_no_ready_busy, clock, reset, state_ff != S_IDLE, !req_chan.ready, "ready while busy")

endmodule

[bench/range_paint_distinct_count_core_test.sv]
`timescale 1ns / 1ps
module range_paint_distinct_count_core_test;
   import rpdc_pkg::*;

   class paint_scoreboard;
      logic [LABEL_W-1:0] position_label [POSITIONS_DEF];
      int                 usable;
      logic [COUNT_W-1:0] expected_counts [$];
      bit                 failed;

      function new();
         foreach (position_label[i]) position_label[i] = '0;
         usable = POSITIONS_DEF;
         failed = 0;
      endfunction

      function void set_limit(logic [CSR_W-1:0] v);
         usable = (v == 0) ? 1 : ((v > POSITIONS_DEF) ? POSITIONS_DEF : int'(v));
      endfunction

      function void note_command(opcode_type op, int lo, int hi, logic [LABEL_W-1:0] lab);
         bit seen [LABELS_DEF];
         int visible;
         visible = 0;
         if (hi > usable - 1) hi = usable - 1;
         case (op)
            OP_CLEAR: foreach (position_label[i]) position_label[i] = '0;
            OP_PAINT: for (int p = lo; p <= hi; p++) position_label[p] = lab;
            OP_COUNT: for (int p = lo; p <= hi; p++) begin
               if (position_label[p] != 0 && !seen[position_label[p]]) begin
                  seen[position_label[p]] = 1;
                  visible++;
               end
            end
            default: ;
         endcase
         if (visible > COUNT_MAX) visible = COUNT_MAX;
         expected_counts.push_back(COUNT_W'(visible));
      endfunction

      function void check_result(logic [COUNT_W-1:0] got);
         logic [COUNT_W-1:0] want;
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %0d", $time, got);
            failed = 1;
            return;
         end
         want = expected_counts.pop_front();
         if (got !== want) begin
            $display("%0t: distinct_count mismatch, expected %0d, actual %0d",
                     $time, want, got);
            failed = 1;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_W-1:0] csr_wdata = '0;
   paint_scoreboard board = new();

   rpdc_req_if req_chan ();
   rpdc_rsp_if rsp_chan ();

   range_paint_distinct_count_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic send_command(opcode_type op, int lo, int hi, int lab);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.opcode <= op;
      req_chan.range_low <= RANGE_W'(lo);
      req_chan.range_high <= RANGE_W'(hi);
      req_chan.label <= LABEL_W'(lab);
      do @(posedge clock); while (!req_chan.ready);
      board.note_command(op, lo, hi, LABEL_W'(lab));
   endtask

   task automatic write_limit(logic [CSR_W-1:0] v);
      req_chan.valid <= 0;
      @(posedge clock);
      while (board.expected_counts.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.set_limit(v);
   endtask

   task automatic random_phase(int count, int span);
      opcode_type op;
      int lo, hi, lab, pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) op = OP_CLEAR;
         else if (pick < 48) op = OP_PAINT;
         else if (pick < 93) op = OP_COUNT;
         else op = OP_NONE;
         lab = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1023);
         if ($urandom_range(0, 9) == 0 && span < 64) lab = $urandom_range(1, 4);
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            lo = $urandom_range(0, 4095);
            hi = $urandom_range(0, 4095);
         end else if (pick < 8) begin
            lo = $urandom_range(0, 4095);
            hi = $urandom_range(0, 4095);
            if (board.usable > 256 && hi > lo + 64) hi = lo + 64;
         end else begin
            lo = $urandom_range(0, span - 1);
            hi = lo + $urandom_range(0, 40) - 3;
            if (hi < 0) hi = 0;
            if (hi > 4095) hi = 4095;
         end
         send_command(op, lo, hi, lab);
      end
   endtask

   initial begin
      req_chan.valid = 0;
      req_chan.opcode = '0;
      req_chan.range_low = '0;
      req_chan.range_high = '0;
      req_chan.label = '0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed corners at full size
      send_command(OP_CLEAR, 0, 0, 0);
      send_command(OP_PAINT, 0, 4095, 1023);
      send_command(OP_COUNT, 0, 4095, 0);
      send_command(OP_PAINT, 0, 0, 0);
      send_command(OP_COUNT, 0, 0, 1023);
      send_command(OP_PAINT, 4095, 4095, 5);
      send_command(OP_COUNT, 4094, 4095, 0);
      send_command(OP_PAINT, 10, 5, 9);
      send_command(OP_COUNT, 10, 5, 0);
      send_command(OP_NONE, 4095, 4095, 1023);
      send_command(OP_PAINT, 100, 200, 0);
      send_command(OP_PAINT, 150, 160, 682);
      send_command(OP_PAINT, 155, 155, 341);
      send_command(OP_COUNT, 50, 250, 0);
      send_command(OP_COUNT, 0, 4095, 0);
      send_command(OP_CLEAR, 4095, 4095, 1023);
      send_command(OP_COUNT, 4000, 4095, 0);

      // register out of range at both ends
      write_limit(13'd0);
      send_command(OP_PAINT, 0, 4095, 7);
      send_command(OP_COUNT, 0, 4095, 0);
      send_command(OP_PAINT, 1, 4095, 8);
      send_command(OP_COUNT, 1, 4095, 0);
      write_limit(13'h1fff);
      send_command(OP_COUNT, 0, 4095, 0);
      random_phase(250, 4096);

      write_limit(13'd1);
      random_phase(120, 4);
      write_limit(13'd64);
      random_phase(350, 80);
      write_limit(13'd4096);
      random_phase(250, 4096);
      write_limit(13'd3);
      random_phase(150, 6);
      write_limit(CSR_W'($urandom_range(2, 300)));
      random_phase(300, 320);
      write_limit(13'd2);
      random_phase(100, 4);
      write_limit(CSR_W'($urandom_range(4097, 8191)));
      random_phase(130, 4096);

      req_chan.valid <= 0;
      while (board.expected_counts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!board.failed)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      int stall;
      rsp_chan.ready = 0;
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, 9);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
         board.check_result(rsp_chan.distinct_count);
      end
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
